@@ rtl/core/fss_pkg.sv @@
// Shared types, constants and register codes of the fit scaler sample address block.
`default_nettype none
package fss_pkg;

   localparam logic [12:0] MAX_SRC_DIM = 13'd4096;
   localparam logic [10:0] MAX_DST_DIM = 11'd1024;

   localparam logic [1:0] MODE_STRETCH = 2'd0;
   localparam logic [1:0] MODE_CONTAIN = 2'd1;
   localparam logic [1:0] MODE_COVER   = 2'd2;

   localparam logic [2:0] CSR_SRC_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_SRC_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_DST_WIDTH   = 3'd2;
   localparam logic [2:0] CSR_DST_HEIGHT  = 3'd3;
   localparam logic [2:0] CSR_FIT_MODE    = 3'd4;
   localparam logic [2:0] CSR_TOP_DOWN    = 3'd5;
   localparam logic [2:0] CSR_DATA_OFFSET = 3'd6;
   localparam logic [2:0] CSR_BPP         = 3'd7;

   localparam int DIV_STEPS = 12;

   // Configuration after dimension limiting and pixel size cleanup.
   typedef struct packed {
      logic [12:0] sw;
      logic [12:0] sh;
      logic [10:0] dw;
      logic [10:0] dh;
      logic [1:0]  mode;
      logic        top;
      logic [15:0] offset;
      logic [2:0]  bpp;
   } cfg_type;

   // One axis of a queued request: a numerator, a divisor and a force-to-zero flag.
   typedef struct packed {
      logic [23:0] dividend;
      logic [11:0] divisor;
      logic        zero;
   } qlane_type;

   typedef struct packed {
      qlane_type x;
      qlane_type y;
   } job_type;

   // One axis inside the divider pipeline.
   typedef struct packed {
      logic [23:0] dividend;
      logic [11:0] divisor;
      logic [11:0] rem;
      logic [11:0] quo;
      logic        sat;
      logic        zero;
   } div_lane_type;

endpackage
`default_nettype wire

@@ rtl/core/fit_scaler_sample_address.sv @@
// Top level of the fit scaler sample address block.
//
// Each request carries one destination pixel (dest_x, dest_y). The block
// answers with the nearest-neighbor source pixel of a BMP image and its
// byte address in the file, one response per request, in order.
// The scaling mode, image sizes, row order, pixel size and data offset come
// from eight registers written through the csr_ port; they must only be
// changed while no request is in flight.
// The block takes one request per cycle while req_tready is high and holds no
// state between requests. Without stalls, a request passes four front stages
// that form the divide operands, the queue, thirteen divider stages (a load
// stage, then one quotient bit each), then clamp, multiply and address add.
// A stalled response stops the back pipeline; the queue lets the front keep
// filling until it is full, after which req_tready drops.
// Reset clears all valid flags and loads the register defaults: a 64 by 64
// image on a 64 by 64 panel, contain mode, bottom-up rows, offset 54 and
// three bytes per pixel.
`default_nettype none
module fit_scaler_sample_address (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // dest_x [9:0], dest_y [19:10], zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // source_x [11:0], source_y [23:12],
                                         // stored_row [35:24], byte_address [62:36]
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [12:0] src_w_ff, src_h_ff;
   logic [10:0] dst_w_ff, dst_h_ff;
   logic [1:0]  mode_ff;
   logic        top_ff;
   logic [15:0] offset_ff;
   logic [2:0]  bpp_ff;
   fss_pkg::cfg_type cfg;
   logic             q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   fss_pkg::job_type q_push_job, q_pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff  <= 13'd64;
         src_h_ff  <= 13'd64;
         dst_w_ff  <= 11'd64;
         dst_h_ff  <= 11'd64;
         mode_ff   <= fss_pkg::MODE_CONTAIN;
         top_ff    <= 1'b0;
         offset_ff <= 16'd54;
         bpp_ff    <= 3'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            fss_pkg::CSR_SRC_WIDTH:   src_w_ff  <= csr_wdata[12:0];
            fss_pkg::CSR_SRC_HEIGHT:  src_h_ff  <= csr_wdata[12:0];
            fss_pkg::CSR_DST_WIDTH:   dst_w_ff  <= csr_wdata[10:0];
            fss_pkg::CSR_DST_HEIGHT:  dst_h_ff  <= csr_wdata[10:0];
            fss_pkg::CSR_FIT_MODE:    mode_ff   <= csr_wdata[1:0];
            fss_pkg::CSR_TOP_DOWN:    top_ff    <= csr_wdata[0];
            fss_pkg::CSR_DATA_OFFSET: offset_ff <= csr_wdata;
            fss_pkg::CSR_BPP:         bpp_ff    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Zero sizes count as one and oversized ones saturate; the unused mode
   // code acts as contain, and any pixel size but four acts as three.
   always_comb begin
      cfg.sw = (src_w_ff == 13'd0) ? 13'd1 :
               (src_w_ff > fss_pkg::MAX_SRC_DIM) ? fss_pkg::MAX_SRC_DIM : src_w_ff;
      cfg.sh = (src_h_ff == 13'd0) ? 13'd1 :
               (src_h_ff > fss_pkg::MAX_SRC_DIM) ? fss_pkg::MAX_SRC_DIM : src_h_ff;
      cfg.dw = (dst_w_ff == 11'd0) ? 11'd1 :
               (dst_w_ff > fss_pkg::MAX_DST_DIM) ? fss_pkg::MAX_DST_DIM : dst_w_ff;
      cfg.dh = (dst_h_ff == 11'd0) ? 11'd1 :
               (dst_h_ff > fss_pkg::MAX_DST_DIM) ? fss_pkg::MAX_DST_DIM : dst_h_ff;
      cfg.mode   = (mode_ff == fss_pkg::MODE_STRETCH || mode_ff == fss_pkg::MODE_COVER) ?
                   mode_ff : fss_pkg::MODE_CONTAIN;
      cfg.top    = top_ff;
      cfg.offset = offset_ff;
      cfg.bpp    = (bpp_ff == 3'd4) ? 3'd4 : 3'd3;
   end

   fss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_dx     (req_tdata[9:0]),
      .in_dy     (req_tdata[19:10]),
      .out_valid (q_push_valid),
      .out_ready (q_push_ready),
      .out_job   (q_push_job)
   );

   fss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_job   (q_push_job),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_job    (q_pop_job)
   );

   fss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (q_pop_valid),
      .in_ready  (q_pop_ready),
      .in_job    (q_pop_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

@@ rtl/core/fss_front.sv @@
// Front pipeline: accepts coordinates and forms the divide numerators and divisors.
`default_nettype none
module fss_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fss_pkg::cfg_type  cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [9:0]        in_dx,
   input  wire logic [9:0]        in_dy,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output fss_pkg::job_type       out_job
);

   logic        en;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [9:0]  dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic [23:0] xw1_ff, yw1_ff;
   logic [23:0] spx1_ff, spy1_ff, spx2_ff, spy2_ff, spx3_ff, spy3_ff;
   logic [10:0] num2_ff, num3_ff;
   logic [12:0] den2_ff;
   logic [23:0] ax3_ff, bx3_ff, ay3_ff, by3_ff;
   logic [23:0] xw1_in, yw1_in, spx1_in, spy1_in;
   logic        x_smaller, use_x;
   logic [11:0] span_x, span_y;
   logic [23:0] ax3_in, bx3_in, ay3_in, by3_in;
   fss_pkg::job_type job4_ff, job4_in;

   assign en        = !v4_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = v4_ff;
   assign out_job   = job4_ff;

   // Stage 1: scale comparison products and stretch numerators.
   assign xw1_in  = cfg.dw * cfg.sh;
   assign yw1_in  = cfg.dh * cfg.sw;
   assign spx1_in = in_dx * cfg.sw;
   assign spy1_in = in_dy * cfg.sh;

   // Stage 2: pick the common scale.
   assign x_smaller = xw1_ff <= yw1_ff;
   assign use_x     = (cfg.mode == fss_pkg::MODE_COVER) ? !x_smaller : x_smaller;

   // Stage 3: centered numerators.
   assign span_x = {1'b0, cfg.dw} + {1'b0, dx2_ff, 1'b0};
   assign span_y = {1'b0, cfg.dh} + {1'b0, dy2_ff, 1'b0};
   assign ax3_in = den2_ff * span_x;
   assign bx3_in = cfg.sw * num2_ff;
   assign ay3_in = den2_ff * span_y;
   assign by3_in = cfg.sh * num2_ff;

   // Stage 4: subtract or take the stretch terms.
   always_comb begin
      if (cfg.mode == fss_pkg::MODE_STRETCH) begin
         job4_in.x.dividend = spx3_ff;
         job4_in.x.divisor  = {1'b0, cfg.dw};
         job4_in.x.zero     = 1'b0;
         job4_in.y.dividend = spy3_ff;
         job4_in.y.divisor  = {1'b0, cfg.dh};
         job4_in.y.zero     = 1'b0;
      end else begin
         job4_in.x.dividend = ax3_ff - bx3_ff;
         job4_in.x.divisor  = {num3_ff, 1'b0};
         job4_in.x.zero     = ax3_ff < bx3_ff;
         job4_in.y.dividend = ay3_ff - by3_ff;
         job4_in.y.divisor  = {num3_ff, 1'b0};
         job4_in.y.zero     = ay3_ff < by3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff  <= in_dx;
         dy1_ff  <= in_dy;
         xw1_ff  <= xw1_in;
         yw1_ff  <= yw1_in;
         spx1_ff <= spx1_in;
         spy1_ff <= spy1_in;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         spx2_ff <= spx1_ff;
         spy2_ff <= spy1_ff;
         num2_ff <= use_x ? cfg.dw : cfg.dh;
         den2_ff <= use_x ? cfg.sw : cfg.sh;
         spx3_ff <= spx2_ff;
         spy3_ff <= spy2_ff;
         num3_ff <= num2_ff;
         ax3_ff  <= ax3_in;
         bx3_ff  <= bx3_in;
         ay3_ff  <= ay3_in;
         by3_ff  <= by3_in;
         job4_ff <= job4_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/fss_queue.sv @@
// Two-entry queue between the front and back pipelines.
`default_nettype none
module fss_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire fss_pkg::job_type  push_job,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output fss_pkg::job_type       pop_job
);

   fss_pkg::job_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff)) else $error("queue pointers disagree");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1)) else $error("queue lost a push");

endmodule
`default_nettype wire

@@ rtl/core/fss_back.sv @@
// Back pipeline: pipelined divider, clamping, row flip and byte address.
`default_nettype none
module fss_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fss_pkg::cfg_type  cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire fss_pkg::job_type  in_job,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [63:0]            out_data
);

   localparam int N = fss_pkg::DIV_STEPS;

   logic                  en;
   logic                  dv_ff [N+1];
   fss_pkg::div_lane_type dx_ff [N+1];
   fss_pkg::div_lane_type dy_ff [N+1];
   fss_pkg::div_lane_type dx0_in, dy0_in;
   logic        vc_ff, vm_ff, vo_ff;
   logic [11:0] sxc_ff, syc_ff, rowc_ff, sxm_ff, sym_ff, rowm_ff;
   logic [11:0] sxo_ff, syo_ff, rowo_ff;
   logic [25:0] rprod_m_ff;
   logic [13:0] cprod_m_ff;
   logic [26:0] addr_o_ff;
   logic [11:0] sx_c_in, sy_c_in, row_c_in;
   logic [14:0] stride;
   logic [25:0] rprod_m_in;
   logic [13:0] cprod_m_in;

   assign en        = !vo_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = vo_ff;
   assign out_data  = {1'b0, addr_o_ff, rowo_ff, syo_ff, sxo_ff};

   function automatic fss_pkg::div_lane_type fss_init(fss_pkg::qlane_type q);
      fss_pkg::div_lane_type d;
      d.dividend = q.dividend;
      d.divisor  = q.divisor;
      d.zero     = q.zero;
      d.quo      = 12'd0;
      d.sat      = q.dividend[23:12] >= q.divisor;
      d.rem      = d.sat ? 12'd0 : q.dividend[23:12];
      return d;
   endfunction

   function automatic logic [11:0] fss_settle(fss_pkg::div_lane_type d, logic [12:0] slen);
      logic [12:0] top;
      top = slen - 13'd1;
      if (d.zero) return 12'd0;
      if (d.sat || ({1'b0, d.quo} > top)) return top[11:0];
      return d.quo;
   endfunction

   assign dx0_in = fss_init(in_job.x);
   assign dy0_in = fss_init(in_job.y);

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else if (en) dv_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff[0] <= dx0_in;
         dy_ff[0] <= dy0_in;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar i = 1; i <= N; i++) begin : g_div
      localparam int B = N - i;
      fss_pkg::div_lane_type nx, ny;
      logic [12:0] tx, ty;

      always_comb begin
         nx = dx_ff[i-1];
         ny = dy_ff[i-1];
         tx = {dx_ff[i-1].rem, dx_ff[i-1].dividend[B]};
         ty = {dy_ff[i-1].rem, dy_ff[i-1].dividend[B]};
         nx.quo[B] = tx >= {1'b0, dx_ff[i-1].divisor};
         ny.quo[B] = ty >= {1'b0, dy_ff[i-1].divisor};
         nx.rem = nx.quo[B] ? 12'(tx - {1'b0, dx_ff[i-1].divisor}) : tx[11:0];
         ny.rem = ny.quo[B] ? 12'(ty - {1'b0, dy_ff[i-1].divisor}) : ty[11:0];
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[i] <= 1'b0;
         else if (en) dv_ff[i] <= dv_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dx_ff[i] <= nx;
            dy_ff[i] <= ny;
         end
      end
   end

   assign sx_c_in  = fss_settle(dx_ff[N], cfg.sw);
   assign sy_c_in  = fss_settle(dy_ff[N], cfg.sh);
   assign row_c_in = cfg.top ? sy_c_in : 12'(cfg.sh - 13'd1 - {1'b0, sy_c_in});

   assign stride     = 15'((cfg.sw * cfg.bpp) + 16'd3) & ~15'd3;
   assign rprod_m_in = rowc_ff * stride;
   assign cprod_m_in = sxc_ff * cfg.bpp;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vm_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= dv_ff[N];
         vm_ff <= vc_ff;
         vo_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sxc_ff     <= sx_c_in;
         syc_ff     <= sy_c_in;
         rowc_ff    <= row_c_in;
         sxm_ff     <= sxc_ff;
         sym_ff     <= syc_ff;
         rowm_ff    <= rowc_ff;
         rprod_m_ff <= rprod_m_in;
         cprod_m_ff <= cprod_m_in;
         sxo_ff     <= sxm_ff;
         syo_ff     <= sym_ff;
         rowo_ff    <= rowm_ff;
         addr_o_ff  <= 27'({11'd0, cfg.offset} + {1'b0, rprod_m_ff} + {13'd0, cprod_m_ff});
      end
   end

endmodule
`default_nettype wire
